// ----- src/two_key_priority_queue_defines.svh -----
// -----------------------------------------------------------------------------
// Two-key priority queue: assertion macros
// Shared assertion forms for the checker, one clocked form with reset
// qualification and one that stays active during reset.
// -----------------------------------------------------------------------------
`ifndef TWO_KEY_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_KEY_PRIORITY_QUEUE_DEFINES_SVH

// Checked only while the block is out of reset.
`define TKPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TKPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tkpq_pkg.sv -----
// -----------------------------------------------------------------------------
// Two-key priority queue package
// Entry type, field widths, operation and outcome codes, and the ordering
// function used by the cells.
// -----------------------------------------------------------------------------
package tkpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int LEVEL_W      = 2;
    localparam int ARRIVAL_W    = 32;
    localparam int TAG_W        = 16;
    localparam int OCC_W        = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        OUT_PUSHED   = 2'd0,
        OUT_POPPED   = 2'd1,
        OUT_EMPTY    = 2'd2,
        OUT_REJECTED = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [ARRIVAL_W-1:0] arrival;
        logic [TAG_W-1:0]     tag;
    } t_entry;

    // Operation broadcast to every cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_op;

    // True when entry x must be served strictly before entry y.
    function automatic logic served_before(t_entry x, t_entry y);
        logic result;
        if (x.level != y.level) begin
            result = (x.level < y.level);
        end else begin
            result = (x.arrival < y.arrival);
        end
        return result;
    endfunction

endpackage

// ----- src/tkpq_req_if.sv -----
// -----------------------------------------------------------------------------
// Two-key priority queue request channel
// Valid/ready channel carrying one push or pop request word.
// -----------------------------------------------------------------------------
interface tkpq_req_if
    import tkpq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [LEVEL_W-1:0]   level;
    logic [ARRIVAL_W-1:0] arrival;
    logic [TAG_W-1:0]     tag;

    modport source (output valid, kind, level, arrival, tag, input ready);
    modport sink   (input valid, kind, level, arrival, tag, output ready);
endinterface

// ----- src/tkpq_rsp_if.sv -----
// -----------------------------------------------------------------------------
// Two-key priority queue response channel
// Valid/ready channel carrying one result word per request.
// -----------------------------------------------------------------------------
interface tkpq_rsp_if
    import tkpq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           outcome;
    logic [LEVEL_W-1:0]   out_level;
    logic [ARRIVAL_W-1:0] out_arrival;
    logic [TAG_W-1:0]     out_tag;
    logic [OCC_W-1:0]     occupancy;
    logic                 is_empty;

    modport source (output valid, outcome, out_level, out_arrival, out_tag, occupancy,
                    is_empty, input ready);
    modport sink   (input valid, outcome, out_level, out_arrival, out_tag, occupancy,
                    is_empty, output ready);
endinterface

// ----- src/tkpq_cell.sv -----
// -----------------------------------------------------------------------------
// Two-key priority queue cell
// Holds one queue slot. On a push it compares the new entry with its own and
// either keeps its entry, takes the new one or takes its left neighbor's;
// on a pop it takes its right neighbor's entry.
// -----------------------------------------------------------------------------
module tkpq_cell
    import tkpq_pkg::*;
(
    input  logic     i_clk,
    input  t_cell_op i_op,
    input  t_entry   i_new,
    input  logic     i_valid,
    input  t_entry   i_left_entry,
    input  logic     i_left_cmp,
    input  t_entry   i_right_entry,
    output t_entry   o_entry,
    output logic     o_cmp
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_cmp;

    // An empty slot ranks behind any new entry. Because the row is sorted,
    // the compare flags form a run of zeros followed by ones.
    assign w_cmp = !i_valid || served_before(i_new, r_entry);

    always_comb begin
        n_entry = r_entry;
        if (i_op.push) begin
            if (i_left_cmp) begin
                n_entry = i_left_entry;
            end else if (w_cmp) begin
                n_entry = i_new;
            end
        end else if (i_op.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_cmp   = w_cmp;

endmodule

// ----- src/two_key_priority_queue.sv -----
// -----------------------------------------------------------------------------
// Two-key priority queue
// Bounded queue sorted by level, then arrival, with ties kept in push order.
// -----------------------------------------------------------------------------
// The row of CAPACITY cells inserts or removes on each accepted word, each
// cell comparing the new entry with its own slot and shifting with its
// neighbors, so a word is accepted every cycle unless the response register
// is full and stalled. The response is registered and appears in the cycle after
// acceptance. Pushes on a full queue and pops on an empty queue
// leave the queue unchanged and report their own outcome. Occupancy is shown
// in five bits.
module two_key_priority_queue
    import tkpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    tkpq_req_if.sink     i_req,
    tkpq_rsp_if.source   o_rsp
);

    localparam int HELD_W = $clog2(CAPACITY + 1);

    logic [HELD_W-1:0]    r_held;
    logic [HELD_W-1:0]    n_held;
    logic                 r_out_valid;
    t_outcome             r_outcome;
    t_outcome             n_outcome;
    logic [LEVEL_W-1:0]   r_out_level;
    logic [ARRIVAL_W-1:0] r_out_arrival;
    logic [TAG_W-1:0]     r_out_tag;
    logic [OCC_W-1:0]     r_occupancy;
    logic                 r_is_empty;

    logic     w_accept;
    logic     w_full;
    logic     w_empty;
    t_cell_op w_op;
    t_entry   w_new;
    t_entry   w_entry [CAPACITY];
    logic     w_cmp   [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_held == HELD_W'(CAPACITY));
    assign w_empty     = (r_held == '0);

    assign w_new.level   = i_req.level;
    assign w_new.arrival = i_req.arrival;
    assign w_new.tag     = i_req.tag;

    assign w_op.push = w_accept && (i_req.kind == KIND_PUSH) && !w_full;
    assign w_op.pop  = w_accept && (i_req.kind == KIND_POP) && !w_empty;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_entry w_left_entry;
        logic   w_left_cmp;
        t_entry w_right_entry;
        logic   w_valid;

        assign w_valid = (HELD_W'(i) < r_held);

        if (i == 0) begin : g_head
            assign w_left_entry = w_new;
            assign w_left_cmp   = 1'b0;
        end else begin : g_body
            assign w_left_entry = w_entry[i-1];
            assign w_left_cmp   = w_cmp[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_right_entry = w_entry[i];
        end else begin : g_inner
            assign w_right_entry = w_entry[i+1];
        end

        tkpq_cell u_cell (
            .i_clk         (i_clk),
            .i_op          (w_op),
            .i_new         (w_new),
            .i_valid       (w_valid),
            .i_left_entry  (w_left_entry),
            .i_left_cmp    (w_left_cmp),
            .i_right_entry (w_right_entry),
            .o_entry       (w_entry[i]),
            .o_cmp         (w_cmp[i])
        );
    end

    always_comb begin
        n_held = r_held;
        if (i_req.kind == KIND_PUSH) begin
            n_outcome = w_full ? OUT_REJECTED : OUT_PUSHED;
        end else begin
            n_outcome = w_empty ? OUT_EMPTY : OUT_POPPED;
        end
        if (w_op.push) begin
            n_held = r_held + 1'b1;
        end else if (w_op.pop) begin
            n_held = r_held - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_held <= n_held;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_outcome   <= n_outcome;
            r_occupancy <= OCC_W'(n_held);
            r_is_empty  <= (n_held == '0);
            if (w_op.pop) begin
                r_out_level   <= w_entry[0].level;
                r_out_arrival <= w_entry[0].arrival;
                r_out_tag     <= w_entry[0].tag;
            end else begin
                r_out_level   <= '0;
                r_out_arrival <= '0;
                r_out_tag     <= '0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.outcome     = r_outcome;
    assign o_rsp.out_level   = r_out_level;
    assign o_rsp.out_arrival = r_out_arrival;
    assign o_rsp.out_tag     = r_out_tag;
    assign o_rsp.occupancy   = r_occupancy;
    assign o_rsp.is_empty    = r_is_empty;

endmodule

// ----- src/tkpq_checker.sv -----
// -----------------------------------------------------------------------------
// Two-key priority queue checker
// Watches the top-level ports and checks the response word over time.
// -----------------------------------------------------------------------------
`include "two_key_priority_queue_defines.svh"

module tkpq_checker
    import tkpq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 i_req_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic [1:0]           i_outcome,
    input logic [LEVEL_W-1:0]   i_out_level,
    input logic [ARRIVAL_W-1:0] i_out_arrival,
    input logic [TAG_W-1:0]     i_out_tag,
    input logic [OCC_W-1:0]     i_occupancy,
    input logic                 i_is_empty
);

    // A stalled response word must hold until it is taken.
    `TKPQ_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_outcome) && $stable(i_out_tag) && $stable(i_occupancy), "response word changed while stalled")

    // The empty flag and the occupancy describe the same count.
    `TKPQ_ASSERT(a_empty_flag, i_clk, i_rst_n, i_rsp_valid |-> (i_is_empty == (i_occupancy == '0)), "empty flag disagrees with occupancy")

    // Only a successful pop carries entry fields.
    `TKPQ_ASSERT(a_no_entry, i_clk, i_rst_n, i_rsp_valid && (i_outcome != OUT_POPPED) |-> (i_out_level == '0) && (i_out_arrival == '0) && (i_out_tag == '0), "entry fields set without a pop")

    // An accepted request always yields a response on the next cycle.
    `TKPQ_ASSERT(a_rsp_follows, i_clk, i_rst_n, i_req_valid && i_req_ready |=> i_rsp_valid, "accepted request gave no response")

    // Reset empties the response register.
    `TKPQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_rsp_valid, "response valid after reset")

endmodule

bind two_key_priority_queue tkpq_checker u_tkpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_outcome     (o_rsp.outcome),
    .i_out_level   (o_rsp.out_level),
    .i_out_arrival (o_rsp.out_arrival),
    .i_out_tag     (o_rsp.out_tag),
    .i_occupancy   (o_rsp.occupancy),
    .i_is_empty    (o_rsp.is_empty)
);
